// ----- rtl/restoring_divider_64_assert.svh -----
// Assertion macros for the divider RTL.
`ifndef RESTORING_DIVIDER_64_ASSERT_SVH
`define RESTORING_DIVIDER_64_ASSERT_SVH

// Property that must hold in the same cycle.
`define RDV_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define RDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rdv_pkg.sv -----
// Package: widths, per-stage payload type and helpers for the divider.
package rdv_pkg;

  // Width of the operand and result fields on the stream ports.
  localparam int unsigned FIELD_W = 64;
  // Core division width (at most FIELD_W); field bits above it are ignored.
  localparam int unsigned WIDTH   = 64;

  // Payload carried from cell to cell.
  typedef struct packed {
    logic             dz;     // divisor was zero
    logic             q_neg;  // quotient must be negated
    logic             r_neg;  // remainder must be negated
    logic [WIDTH-1:0] rem;    // partial remainder
    logic [WIDTH-1:0] nq;     // dividend bits left, quotient bits shifted in below
    logic [WIDTH-1:0] dvs;    // divisor magnitude
  } rdv_work_t;

  // Zero-extend a core-width value to a field.
  function automatic logic [FIELD_W-1:0] widen(input logic [WIDTH-1:0] x);
    logic [FIELD_W-1:0] r;
    r = '0;
    r[WIDTH-1:0] = x;
    return r;
  endfunction

endpackage

// ----- rtl/rdv_pre.sv -----
// Input stage: operand magnitudes, sign bookkeeping and zero-divisor detect.
module rdv_pre (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic                            kind_i,
  input  logic [rdv_pkg::WIDTH-1:0]       dividend_i,
  input  logic [rdv_pkg::WIDTH-1:0]       divisor_i,
  output logic                            vld_o,
  output rdv_pkg::rdv_work_t              data_o
);

  logic               vld_q;
  rdv_pkg::rdv_work_t data_d;
  rdv_pkg::rdv_work_t data_q;
  logic               nneg;
  logic               dneg;

  assign nneg = kind_i & dividend_i[rdv_pkg::WIDTH-1];
  assign dneg = kind_i & divisor_i[rdv_pkg::WIDTH-1];

  always_comb begin
    data_d       = '0;
    data_d.dz    = (divisor_i == '0);
    data_d.q_neg = nneg ^ dneg;
    data_d.r_neg = nneg;
    data_d.rem   = '0;
    data_d.nq    = nneg ? (~dividend_i + 1'b1) : dividend_i;
    data_d.dvs   = dneg ? (~divisor_i + 1'b1) : divisor_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ----- rtl/rdv_cell.sv -----
// One restoring-division step: shift in a dividend bit, trial subtract, keep or restore.
module rdv_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  rdv_pkg::rdv_work_t data_i,
  output logic               vld_o,
  output rdv_pkg::rdv_work_t data_o
);

  logic                        vld_q;
  rdv_pkg::rdv_work_t          data_d;
  rdv_pkg::rdv_work_t          data_q;
  logic                        carry;
  logic [rdv_pkg::WIDTH-1:0]   sh;
  logic [rdv_pkg::WIDTH:0]     diff;
  logic                        take;

  // carry is the bit shifted out of the partial remainder; with it set the
  // subtraction always fits and wraps back into WIDTH bits.
  assign carry = data_i.rem[rdv_pkg::WIDTH-1];
  assign sh    = {data_i.rem[rdv_pkg::WIDTH-2:0], data_i.nq[rdv_pkg::WIDTH-1]};
  assign diff  = {1'b0, sh} - {1'b0, data_i.dvs};
  assign take  = carry | ~diff[rdv_pkg::WIDTH];

  always_comb begin
    data_d     = data_i;
    data_d.rem = take ? diff[rdv_pkg::WIDTH-1:0] : sh;
    data_d.nq  = {data_i.nq[rdv_pkg::WIDTH-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ----- rtl/rdv_post.sv -----
// Output stage: sign fix-up, zero-divisor override and the output register.
`include "restoring_divider_64_assert.svh"

module rdv_post (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  rdv_pkg::rdv_work_t        data_i,
  output logic                      vld_o,
  output logic [rdv_pkg::WIDTH-1:0] quotient_o,
  output logic [rdv_pkg::WIDTH-1:0] remainder_o,
  output logic                      dz_o
);

  logic                      vld_q;
  logic [rdv_pkg::WIDTH-1:0] q_d;
  logic [rdv_pkg::WIDTH-1:0] q_q;
  logic [rdv_pkg::WIDTH-1:0] r_d;
  logic [rdv_pkg::WIDTH-1:0] r_q;
  logic                      dz_q;

  always_comb begin
    if (data_i.dz) begin
      q_d = '0;
      r_d = '0;
    end else begin
      q_d = data_i.q_neg ? (~data_i.nq + 1'b1) : data_i.nq;
      r_d = data_i.r_neg ? (~data_i.rem + 1'b1) : data_i.rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q  <= q_d;
      r_q  <= r_d;
      dz_q <= data_i.dz;
    end
  end

  assign vld_o       = vld_q;
  assign quotient_o  = q_q;
  assign remainder_o = r_q;
  assign dz_o        = dz_q;

  `RDV_ASSERT_NOW(a_rem_below_dvs, !vld_i || data_i.dz || (data_i.rem < data_i.dvs), "partial remainder not below divisor")
  `RDV_ASSERT_NEXT(a_dz_zero, en_i && vld_i && data_i.dz, (q_q == '0) && (r_q == '0), "zero divisor gave nonzero result")
  `RDV_ASSERT_NEXT(a_rem_sign, en_i && vld_i && !data_i.dz && data_i.r_neg && (data_i.rem != '0), r_q[rdv_pkg::WIDTH-1], "remainder lost dividend sign")

endmodule

// ----- rtl/restoring_divider_64.sv -----
// Path from input transaction to result valid: input stage, step cells, output stage registers.
// Throughput: one transaction per cycle while the output is not stalled; one pipeline cell per quotient bit.
// Back-pressure: the output register stalls the whole chain while its result is not taken.
// Reset: rst_ni clears the stage valid bits asynchronously; data registers are not reset.
// Top level: pipelined restoring divider, input stage, chain of step cells, output stage.
module restoring_divider_64 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // [63:0] dividend, [127:64] divisor
  input  logic [0:0]   s_axis_tuser,  // [0] kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // [63:0] quotient, [127:64] remainder
  output logic [0:0]   m_axis_tuser   // [0] divide_by_zero
);

  localparam int unsigned W  = rdv_pkg::WIDTH;
  localparam int unsigned FW = rdv_pkg::FIELD_W;

  logic                       en;
  logic [W:0]                 vld;
  rdv_pkg::rdv_work_t         work [W+1];
  logic                       out_vld;
  logic [W-1:0]               quo;
  logic [W-1:0]               rem;
  logic                       dz;

  // Global advance: move unless a finished result is waiting.
  assign en            = ~out_vld | m_axis_tready;
  assign s_axis_tready = en;

  rdv_pre u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (s_axis_tvalid),
    .kind_i     (s_axis_tuser[0]),
    .dividend_i (s_axis_tdata[W-1:0]),
    .divisor_i  (s_axis_tdata[FW+W-1:FW]),
    .vld_o      (vld[0]),
    .data_o     (work[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_cell
    rdv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[k]),
      .data_i (work[k]),
      .vld_o  (vld[k+1]),
      .data_o (work[k+1])
    );
  end

  rdv_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (vld[W]),
    .data_i      (work[W]),
    .vld_o       (out_vld),
    .quotient_o  (quo),
    .remainder_o (rem),
    .dz_o        (dz)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {rdv_pkg::widen(rem), rdv_pkg::widen(quo)};
  assign m_axis_tuser  = dz;

endmodule
